>>> rtl/core/obstacle_point_map_and_clearance_macros.svh
// Assertion helpers used by the checker file.
`ifndef OBSTACLE_POINT_MAP_AND_CLEARANCE_MACROS_SVH
`define OBSTACLE_POINT_MAP_AND_CLEARANCE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define OPM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define OPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/opm_pkg.sv
package opm_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  localparam int COORD_W     = 18;
  localparam int LIM_W       = 17;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int OBS_CNT_W   = 11;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT = 2'd2;

  // Item kinds
  localparam logic REQ_POINT    = 1'b0;
  localparam logic REQ_SCAN_END = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam logic [LIM_W-1:0] X_LIMIT_RST    = 17'd5000;
  localparam logic [LIM_W-1:0] Y_LIMIT_RST    = 17'd5000;
  localparam coord_t           MIN_HEIGHT_RST = 18'sd200;

  localparam coord_t Z_CEILING = 18'sd2000;
  localparam coord_t HIGH_TOOL = 18'sd500;
  localparam coord_t LOW_TOOL  = 18'sd300;

  localparam logic [DIFF_W-1:0]        SAME_XY   = 19'd200;
  localparam logic [DIFF_W-1:0]        SAME_Z    = 19'd100;
  localparam logic [DIFF_W-1:0]        DANGER_XY = 19'd1200;
  localparam logic signed [DIFF_W-1:0] DANGER_Z  = 19'sd300;

  // Truncating division by the grid steps: multiply by a rounded-up
  // reciprocal, exact for every 18 bit magnitude.
  localparam int XY_QUANT    = 100;
  localparam int Z_QUANT     = 50;
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP_W     = 20;
  localparam int QUOT_W      = 13;
  localparam int PROD_W      = COORD_W + RECIP_W;
  localparam int SCALE_W     = QUOT_W + 7;
  localparam logic [RECIP_W-1:0] RECIP_XY =
    RECIP_W'(((1 << RECIP_SHIFT) + XY_QUANT - 1) / XY_QUANT);
  localparam logic [RECIP_W-1:0] RECIP_Z =
    RECIP_W'(((1 << RECIP_SHIFT) + Z_QUANT - 1) / Z_QUANT);

  typedef enum logic [1:0] {
    ARM_NONE      = 2'd0,
    ARM_FAST_UP   = 2'd1,
    ARM_SLOW_DOWN = 2'd2,
    ARM_SLOW_UP   = 2'd3
  } arm_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUOT,
    ST_QUANT,
    ST_SCAN,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic   req_type;
    coord_t base_x;
    coord_t base_y;
    coord_t base_z;
    coord_t world_x;
    coord_t world_y;
    coord_t world_z;
    coord_t tool_x;
    coord_t tool_y;
    coord_t tool_z;
    coord_t tool_ground_z;
  } item_t;

  typedef struct packed {
    logic                 point_added;
    logic                 store_full;
    arm_cmd_e             arm_command;
    logic [OBS_CNT_W-1:0] obstacle_count;
  } result_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } entry_t;

  typedef struct packed {
    logic start;   // capture a new word, clear scan state
    logic quot;    // register quotients and the filter result
    logic quant;   // register the comparison reference
    logic scan;    // step through the store
    logic commit;  // update the store and load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic is_point;
    logic keep;
    logic scan_done;
  } dp_status_t;

endpackage

>>> rtl/core/opm_if.sv
interface opm_item_if;
  import opm_pkg::*;

  logic   valid;
  logic   ready;
  logic   req_type;
  coord_t base_x;
  coord_t base_y;
  coord_t base_z;
  coord_t world_x;
  coord_t world_y;
  coord_t world_z;
  coord_t tool_x;
  coord_t tool_y;
  coord_t tool_z;
  coord_t tool_ground_z;

  modport source (
    output valid, req_type, base_x, base_y, base_z, world_x, world_y, world_z,
           tool_x, tool_y, tool_z, tool_ground_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, base_x, base_y, base_z, world_x, world_y, world_z,
           tool_x, tool_y, tool_z, tool_ground_z,
    output ready
  );
endinterface

interface opm_result_if;
  import opm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 point_added;
  logic                 store_full;
  logic [1:0]           arm_command;
  logic [OBS_CNT_W-1:0] obstacle_count;

  modport source (
    output valid, point_added, store_full, arm_command, obstacle_count,
    input  ready
  );
  modport sink (
    input  valid, point_added, store_full, arm_command, obstacle_count,
    output ready
  );
endinterface

interface opm_cfg_if;
  import opm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COORD_W-1:0]   data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

>>> rtl/core/opm_ctrl.sv
module opm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  opm_pkg::dp_status_t sts_i,
  output opm_pkg::dp_cmd_t    cmd_o
);
  import opm_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_QUOT;
      end
      ST_QUOT: begin
        state_d = ST_QUANT;
      end
      ST_QUANT: begin
        if (sts_i.is_point && !sts_i.keep) state_d = ST_FINISH;
        else state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    cmd_o.start  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.quot   = (state_q == ST_QUOT);
    cmd_o.quant  = (state_q == ST_QUANT);
    cmd_o.scan   = (state_q == ST_SCAN);
    cmd_o.commit = (state_q == ST_FINISH) && out_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/core/opm_dp.sv
module opm_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  opm_pkg::item_t                  item_i,
  input  logic                            cfg_we_i,
  input  logic [opm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [opm_pkg::COORD_W-1:0]     cfg_data_i,
  input  opm_pkg::dp_cmd_t                cmd_i,
  output opm_pkg::dp_status_t             sts_o,
  output opm_pkg::result_t                res_o
);
  import opm_pkg::*;

  function automatic logic [COORD_W-1:0] mag18(coord_t v);
    return v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
  endfunction

  function automatic logic [DIFF_W-1:0] mag19(logic signed [DIFF_W-1:0] v);
    return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

  // Configuration registers
  logic [LIM_W-1:0] x_limit_q, y_limit_q;
  coord_t           min_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_limit_q    <= X_LIMIT_RST;
      y_limit_q    <= Y_LIMIT_RST;
      min_height_q <= MIN_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_X_LIMIT:    x_limit_q    <= cfg_data_i[LIM_W-1:0];
        CFG_Y_LIMIT:    y_limit_q    <= cfg_data_i[LIM_W-1:0];
        CFG_MIN_HEIGHT: min_height_q <= coord_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Captured word
  item_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) item_q <= item_i;
  end

  // Filter and reciprocal multiply
  logic              in_x, in_y, in_zc, in_min;
  logic [PROD_W-1:0] prod_x, prod_y, prod_z;
  logic [QUOT_W-1:0] quot_x_q, quot_y_q, quot_z_q;
  logic              keep_q;

  assign in_x   = $signed({item_q.base_x[COORD_W-1], item_q.base_x})
                  < $signed({2'b00, x_limit_q});
  assign in_y   = mag18(item_q.base_y) < {1'b0, y_limit_q};
  assign in_zc  = item_q.base_z < Z_CEILING;
  assign in_min = item_q.base_z > min_height_q;

  assign prod_x = PROD_W'(mag18(item_q.world_x)) * PROD_W'(RECIP_XY);
  assign prod_y = PROD_W'(mag18(item_q.world_y)) * PROD_W'(RECIP_XY);
  assign prod_z = PROD_W'(mag18(item_q.world_z)) * PROD_W'(RECIP_Z);

  always_ff @(posedge clk_i) begin
    if (cmd_i.quot) begin
      quot_x_q <= prod_x[RECIP_SHIFT +: QUOT_W];
      quot_y_q <= prod_y[RECIP_SHIFT +: QUOT_W];
      quot_z_q <= prod_z[RECIP_SHIFT +: QUOT_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= 1'b0;
    end else if (cmd_i.quot) begin
      keep_q <= in_x && in_y && in_zc && in_min;
    end
  end

  // Scale back to the grid, restore sign, pick the reference point
  logic [SCALE_W-1:0] scl_x, scl_y, scl_z;
  coord_t             qx, qy, qz;
  entry_t             ref_q;

  assign scl_x = SCALE_W'(quot_x_q) * SCALE_W'(XY_QUANT);
  assign scl_y = SCALE_W'(quot_y_q) * SCALE_W'(XY_QUANT);
  assign scl_z = SCALE_W'(quot_z_q) * SCALE_W'(Z_QUANT);

  assign qx = item_q.world_x[COORD_W-1] ? -coord_t'(scl_x[COORD_W-1:0])
                                        : coord_t'(scl_x[COORD_W-1:0]);
  assign qy = item_q.world_y[COORD_W-1] ? -coord_t'(scl_y[COORD_W-1:0])
                                        : coord_t'(scl_y[COORD_W-1:0]);
  assign qz = item_q.world_z[COORD_W-1] ? -coord_t'(scl_z[COORD_W-1:0])
                                        : coord_t'(scl_z[COORD_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.quant) begin
      if (item_q.req_type == REQ_POINT) begin
        ref_q.x <= qx;
        ref_q.y <= qy;
        ref_q.z <= qz;
      end else begin
        ref_q.x <= item_q.tool_x;
        ref_q.y <= item_q.tool_y;
        ref_q.z <= item_q.tool_z;
      end
    end
  end

  // Obstacle store and scan
  entry_t          mem [STORE_DEPTH];
  entry_t          rd_q;
  logic            rd_vld_q;
  logic [CNT_W-1:0] idx_q, cnt_q;
  logic            more;
  logic            hit_q;
  logic            add, full, new_pt, has_room;
  entry_t          wr_entry;

  assign more     = idx_q < cnt_q;
  assign has_room = cnt_q < CNT_W'(STORE_DEPTH);
  assign new_pt   = (item_q.req_type == REQ_POINT) && keep_q && !hit_q;
  assign add      = new_pt && has_room;
  assign full     = new_pt && !has_room;

  assign wr_entry.x = ref_q.x;
  assign wr_entry.y = ref_q.y;
  assign wr_entry.z = ref_q.z;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && add) mem[cnt_q[ADDR_W-1:0]] <= wr_entry;
    if (cmd_i.scan && more) rd_q <= mem[idx_q[ADDR_W-1:0]];
  end

  // Compare one entry per cycle against the reference
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [DIFF_W-1:0]        adx, ady, adz;
  logic                     same, danger;

  assign dx  = DIFF_W'(ref_q.x) - DIFF_W'(rd_q.x);
  assign dy  = DIFF_W'(ref_q.y) - DIFF_W'(rd_q.y);
  assign dz  = DIFF_W'(ref_q.z) - DIFF_W'(rd_q.z);
  assign adx = mag19(dx);
  assign ady = mag19(dy);
  assign adz = mag19(dz);

  assign same   = (adx <= SAME_XY) && (ady <= SAME_XY) && (adz < SAME_Z);
  assign danger = (adx <= DANGER_XY) && (ady <= DANGER_XY) && (dz <= DANGER_Z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      cnt_q    <= '0;
    end else begin
      rd_vld_q <= cmd_i.scan && more;
      if (cmd_i.start) begin
        idx_q <= '0;
        hit_q <= 1'b0;
      end else begin
        if (cmd_i.scan && more) idx_q <= idx_q + 1'b1;
        if (rd_vld_q && ((item_q.req_type == REQ_POINT) ? same : danger)) hit_q <= 1'b1;
      end
      if (cmd_i.commit && add) cnt_q <= cnt_q + 1'b1;
    end
  end

  // Result register
  arm_cmd_e arm;
  result_t  res_q;

  always_comb begin
    priority if (item_q.req_type == REQ_POINT) arm = ARM_NONE;
    else if (hit_q)                            arm = ARM_FAST_UP;
    else if (item_q.tool_ground_z > HIGH_TOOL) arm = ARM_SLOW_DOWN;
    else if (item_q.tool_ground_z < LOW_TOOL)  arm = ARM_SLOW_UP;
    else                                       arm = ARM_NONE;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q.point_added    <= add;
      res_q.store_full     <= full;
      res_q.arm_command    <= arm;
      res_q.obstacle_count <= OBS_CNT_W'(cnt_q + CNT_W'(add));
    end
  end

  assign res_o           = res_q;
  assign sts_o.is_point  = (item_q.req_type == REQ_POINT);
  assign sts_o.keep      = keep_q;
  assign sts_o.scan_done = !more && !rd_vld_q;

endmodule

>>> rtl/core/obstacle_point_map_and_clearance.sv
// Flow: a point that the range filter rejects skips the store sweep; any other word sweeps
// every stored obstacle before its result word is committed.
// One word at a time: a new word is accepted only after the last one is committed;
// the store has one read port for the sweep; a stalled result word delays the next commit.
// Reset: asynchronous, active low; clears the controller, the entry count and the
// limit registers; the store itself holds garbage that is never read before it is written.
module obstacle_point_map_and_clearance (
  input  logic          clk_i,
  input  logic          rst_ni,
  opm_item_if.sink      item_i,
  opm_result_if.source  result_o,
  opm_cfg_if.sink       cfg_i
);
  import opm_pkg::*;

  item_t      item;
  dp_cmd_t    cmd;
  dp_status_t sts;
  result_t    res;
  logic       in_ready, out_valid;

  // Pack the incoming word; the datapath registers it on accept.
  assign item.req_type      = item_i.req_type;
  assign item.base_x        = item_i.base_x;
  assign item.base_y        = item_i.base_y;
  assign item.base_z        = item_i.base_z;
  assign item.world_x       = item_i.world_x;
  assign item.world_y       = item_i.world_y;
  assign item.world_z       = item_i.world_z;
  assign item.tool_x        = item_i.tool_x;
  assign item.tool_y        = item_i.tool_y;
  assign item.tool_z        = item_i.tool_z;
  assign item.tool_ground_z = item_i.tool_ground_z;

  // Take configuration writes at any time; the limits are sampled as each word is filtered.
  assign cfg_i.ready = 1'b1;

  // Sequencer: accept, divide to grid, build reference, sweep store (skipped for a rejected point), commit.
  opm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Filter, quantizer, obstacle store, comparator and result register.
  opm_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (res)
  );

  // Ready drops while a word is in flight; the result register frees the
  // input side as soon as its word is committed, even if the sink stalls.
  assign item_i.ready            = in_ready;
  assign result_o.valid          = out_valid;
  assign result_o.point_added    = res.point_added;
  assign result_o.store_full     = res.store_full;
  assign result_o.arm_command    = res.arm_command;
  assign result_o.obstacle_count = res.obstacle_count;

endmodule

>>> rtl/core/opm_checker.sv
`include "obstacle_point_map_and_clearance_macros.svh"

module opm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic                            point_added_i,
  input logic                            store_full_i,
  input logic [1:0]                      arm_command_i,
  input logic [opm_pkg::OBS_CNT_W-1:0]   obstacle_count_i
);
  import opm_pkg::*;

  // Hold a stalled result word.
  `OPM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(obstacle_count_i) && $stable(arm_command_i),
    "result word changed while stalled")

  // Drop ready after a word is taken: one word in flight.
  `OPM_ASSERT_NEXT(a_one_word, clk_i, rst_ni, in_valid_i && in_ready_i,
    !in_ready_i, "second word accepted while busy")

  `OPM_ASSERT_NOW(a_add_xor_full, clk_i, rst_ni, out_valid_i,
    !(point_added_i && store_full_i), "point both added and dropped")

  `OPM_ASSERT_NOW(a_full_count, clk_i, rst_ni, out_valid_i && store_full_i,
    obstacle_count_i == OBS_CNT_W'(STORE_DEPTH), "store full below depth")

  `OPM_ASSERT_NOW(a_arm_on_point, clk_i, rst_ni,
    out_valid_i && (point_added_i || store_full_i),
    arm_command_i == ARM_NONE, "arm command on a point word")

endmodule

bind obstacle_point_map_and_clearance opm_checker u_opm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (item_i.valid),
  .in_ready_i       (item_i.ready),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .point_added_i    (result_o.point_added),
  .store_full_i     (result_o.store_full),
  .arm_command_i    (result_o.arm_command),
  .obstacle_count_i (result_o.obstacle_count)
);

>>> verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import opm_pkg::*;

  // Index 3 has no register behind it; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int QUIET_LIMIT     = 20000;  // cycles with no handshake at all
  localparam int HOLD_OFF_CYCLES = 2000;   // long result back-pressure window
  localparam int ITEMS_PER_PHASE = 110;

  typedef struct {
    item_t   word;
    bit      typed;  // expectation written by hand in the table
    result_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  opm_item_if   item_bus ();
  opm_result_if res_bus ();
  opm_cfg_if    cfg_bus ();

  obstacle_point_map_and_clearance DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (res_bus),
    .cfg_i    (cfg_bus)
  );

  // Mirror of the block: register copies, obstacle store and entry count.
  logic [LIM_W-1:0] fwd_lim  = X_LIMIT_RST;
  logic [LIM_W-1:0] side_lim = Y_LIMIT_RST;
  coord_t           floor_h  = MIN_HEIGHT_RST;
  entry_t           obs_mirror [STORE_DEPTH];
  int               obs_total = 0;

  // Result words owed by the block, oldest first.
  result_t pending_words [$];

  // Directed stimulus table.
  stim_row_t script [$];

  int  n_bad         = 0;
  int  send_idle_pct = 0;
  int  stall_pct     = 0;
  bit  hold_off_req  = 1'b0;

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic coord_t rnd_coord();
    return coord_t'($urandom());
  endfunction

  // Work out the result word of one accepted item and advance the mirror.
  function automatic result_t map_and_clear(input item_t it);
    result_t r;
    int      qx, qy, qz;
    bit      hit;
    r   = '0;
    hit = 1'b0;
    if (it.req_type == REQ_POINT) begin
      if (int'(it.base_x) < int'(fwd_lim) && mag(int'(it.base_y)) < int'(side_lim) &&
          it.base_z < Z_CEILING && it.base_z > floor_h) begin
        // integer division truncates toward zero, as the grid snap does
        qx = (int'(it.world_x) / XY_QUANT) * XY_QUANT;
        qy = (int'(it.world_y) / XY_QUANT) * XY_QUANT;
        qz = (int'(it.world_z) / Z_QUANT) * Z_QUANT;
        for (int i = 0; i < obs_total; i++) begin
          if (mag(qx - int'(obs_mirror[i].x)) <= int'(SAME_XY) &&
              mag(qy - int'(obs_mirror[i].y)) <= int'(SAME_XY) &&
              mag(qz - int'(obs_mirror[i].z)) < int'(SAME_Z))
            hit = 1'b1;
        end
        if (!hit) begin
          if (obs_total < STORE_DEPTH) begin
            obs_mirror[obs_total] = '{coord_t'(qx), coord_t'(qy), coord_t'(qz)};
            obs_total++;
            r.point_added = 1'b1;
          end else begin
            r.store_full = 1'b1;
          end
        end
      end
    end else begin
      for (int i = 0; i < obs_total; i++) begin
        if (mag(int'(it.tool_x) - int'(obs_mirror[i].x)) <= int'(DANGER_XY) &&
            mag(int'(it.tool_y) - int'(obs_mirror[i].y)) <= int'(DANGER_XY) &&
            int'(it.tool_z) - int'(obs_mirror[i].z) <= int'(DANGER_Z))
          hit = 1'b1;
      end
      if (hit)
        r.arm_command = ARM_FAST_UP;
      else if (it.tool_ground_z > HIGH_TOOL)
        r.arm_command = ARM_SLOW_DOWN;
      else if (it.tool_ground_z < LOW_TOOL)
        r.arm_command = ARM_SLOW_UP;
      else
        r.arm_command = ARM_NONE;
    end
    r.obstacle_count = OBS_CNT_W'(obs_total);
    return r;
  endfunction

  function automatic item_t point_item(input int bx, by, bz, wx, wy, wz);
    item_t it;
    it = {1'b0, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
          rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
    it.req_type = REQ_POINT;
    it.base_x  = coord_t'(bx);
    it.base_y  = coord_t'(by);
    it.base_z  = coord_t'(bz);
    it.world_x = coord_t'(wx);
    it.world_y = coord_t'(wy);
    it.world_z = coord_t'(wz);
    return it;
  endfunction

  function automatic item_t scan_item(input int tx, ty, tz, tg);
    item_t it;
    it = point_item(int'(rnd_coord()), int'(rnd_coord()), int'(rnd_coord()),
                    int'(rnd_coord()), int'(rnd_coord()), int'(rnd_coord()));
    it.req_type      = REQ_SCAN_END;
    it.tool_x        = coord_t'(tx);
    it.tool_y        = coord_t'(ty);
    it.tool_z        = coord_t'(tz);
    it.tool_ground_z = coord_t'(tg);
    return it;
  endfunction

  function automatic result_t word(input bit added, full, arm_cmd_e cmd, int cnt);
    result_t r;
    r.point_added    = added;
    r.store_full     = full;
    r.arm_command    = cmd;
    r.obstacle_count = OBS_CNT_W'(cnt);
    return r;
  endfunction

  // Append one row to the directed table.
  task automatic add_row(input item_t w, input bit typed, input result_t want);
    stim_row_t row;
    row.word  = w;
    row.typed = typed;
    row.want  = want;
    script.insert(script.size(), row);
  endtask

  // Mostly points that pass the current filter and land on or near stored
  // obstacles, scan ends around stored obstacles, and some pure noise.
  function automatic item_t random_item();
    item_t       it;
    entry_t      e;
    int unsigned roll;
    int          bx, by, bz, span;
    it = scan_item(int'(rnd_coord()), int'(rnd_coord()), int'(rnd_coord()),
                   int'(rnd_coord()));
    it.req_type = ($urandom_range(99) < 30) ? REQ_SCAN_END : REQ_POINT;
    roll = $urandom_range(99);
    if (roll < 15)
      return it;
    e = '0;
    if (obs_total != 0)
      e = obs_mirror[$urandom_range(obs_total - 1)];
    if (it.req_type == REQ_SCAN_END) begin
      if (obs_total != 0 && roll < 70) begin
        it.tool_x = coord_t'(int'(e.x) + int'($urandom_range(2800)) - 1400);
        it.tool_y = coord_t'(int'(e.y) + int'($urandom_range(2800)) - 1400);
        it.tool_z = coord_t'(int'(e.z) + int'($urandom_range(800)) - 200);
      end
      // half the time sit right on the height thresholds
      if ($urandom_range(1))
        it.tool_ground_z = coord_t'(($urandom_range(1) ? 300 : 500) +
                                    int'($urandom_range(2)) - 1);
      else
        it.tool_ground_z = coord_t'($urandom_range(800));
    end else begin
      bx = int'(fwd_lim) - 1 - int'($urandom_range(6000));
      if ($urandom_range(9) == 0)
        bx = int'(fwd_lim);
      it.base_x = coord_t'(bx);
      if (side_lim != 0) begin
        by = int'($urandom_range(int'(side_lim) - 1));
        if ($urandom_range(1))
          by = -by;
        it.base_y = coord_t'(by);
      end
      if (int'(floor_h) < int'(Z_CEILING) - 1) begin
        span = int'(Z_CEILING) - 2 - int'(floor_h);
        if (span > 4000)
          span = 4000;
        bz = int'(Z_CEILING) - 1 - int'($urandom_range(span));
        if ($urandom_range(9) == 0)
          bz = int'(floor_h);
        it.base_z = coord_t'(bz);
      end
      if (obs_total != 0 && $urandom_range(1)) begin
        it.world_x = coord_t'(int'(e.x) + int'($urandom_range(600)) - 300);
        it.world_y = coord_t'(int'(e.y) + int'($urandom_range(600)) - 300);
        it.world_z = coord_t'(int'(e.z) + int'($urandom_range(300)) - 150);
      end
    end
    return it;
  endfunction

  // Offer one word, hold it until accepted, then book its expected result.
  // Valid is left high on return so a following word can go back to back.
  task automatic offer_item(input item_t it, input bit typed, input result_t want);
    result_t calc;
    while ($urandom_range(99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_bus.valid         <= 1'b1;
    item_bus.req_type      <= it.req_type;
    item_bus.base_x        <= it.base_x;
    item_bus.base_y        <= it.base_y;
    item_bus.base_z        <= it.base_z;
    item_bus.world_x       <= it.world_x;
    item_bus.world_y       <= it.world_y;
    item_bus.world_z       <= it.world_z;
    item_bus.tool_x        <= it.tool_x;
    item_bus.tool_y        <= it.tool_y;
    item_bus.tool_z        <= it.tool_z;
    item_bus.tool_ground_z <= it.tool_ground_z;
    do @(posedge clk_i); while (!item_bus.ready);
    calc = map_and_clear(it);
    pending_words.insert(pending_words.size(), typed ? want : calc);
  endtask

  // Drop valid and wait until every owed result word has come back.
  task automatic drain();
    item_bus.valid <= 1'b0;
    while (pending_words.size() != 0)
      @(posedge clk_i);
  endtask

  // Write the spare index first, then the three real registers back to back.
  task automatic write_regs(input logic [LIM_W-1:0] fwd, side, input coord_t floor_v);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [COORD_W-1:0]   val [4];
    idx = '{CFG_SPARE, CFG_X_LIMIT, CFG_Y_LIMIT, CFG_MIN_HEIGHT};
    // the top data bit is dont-care for the limits; toggle it anyway
    val = '{COORD_W'($urandom()), {1'($urandom()), fwd}, {1'($urandom()), side},
            floor_v};
    for (int k = 0; k < 4; k++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[k];
      cfg_bus.data  <= val[k];
      do @(posedge clk_i); while (!cfg_bus.ready);
      case (idx[k])
        CFG_X_LIMIT:    fwd_lim  = val[k][LIM_W-1:0];
        CFG_Y_LIMIT:    side_lim = val[k][LIM_W-1:0];
        CFG_MIN_HEIGHT: floor_h  = coord_t'(val[k]);
        default: ;
      endcase
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Result side: random stalls per phase, plus one long hold-off on request.
  initial begin : result_sink
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_bus.ready <= 1'b0;
        for (int c = 1; c < HOLD_OFF_CYCLES; c++)
          @(posedge clk_i);
      end else begin
        res_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare every accepted result word against the oldest expectation.
  always @(posedge clk_i) begin : word_check
    result_t got, want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      got.point_added    = res_bus.point_added;
      got.store_full     = res_bus.store_full;
      got.arm_command    = arm_cmd_e'(res_bus.arm_command);
      got.obstacle_count = res_bus.obstacle_count;
      if (pending_words.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("%0t: result word with nothing expected: added %0d full %0d cmd %0d cnt %0d",
                   $realtime, got.point_added, got.store_full, got.arm_command,
                   got.obstacle_count);
      end else begin
        want = pending_words.pop_front();
        if (got.point_added !== want.point_added || got.store_full !== want.store_full ||
            got.arm_command !== want.arm_command ||
            got.obstacle_count !== want.obstacle_count) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: mismatch exp/act: added %0d/%0d full %0d/%0d cmd %0d/%0d cnt %0d/%0d",
                     $realtime, want.point_added, got.point_added, want.store_full,
                     got.store_full, want.arm_command, got.arm_command,
                     want.obstacle_count, got.obstacle_count);
        end
      end
    end
  end

  // Abort when no channel has moved a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int               idle_tab  [5] = '{0, 75, 0, 9, 9};
    int               stall_tab [5] = '{0, 0, 75, 9, 9};
    logic [LIM_W-1:0] fwd_tab   [5] = '{17'd5000, 17'd131071, 17'd0, 17'd20000, 17'd8000};
    logic [LIM_W-1:0] side_tab  [5] = '{17'd5000, 17'd131071, 17'd3000, 17'd0, 17'd8000};
    coord_t           floor_tab [5] = '{18'sd200, -18'sd131072, 18'sd0, 18'sd131071,
                                        -18'sd500};

    // hold every input at a known value from time zero
    item_bus.valid <= 1'b0;
    item_bus.req_type <= REQ_POINT;
    item_bus.base_x <= '0;
    item_bus.base_y <= '0;
    item_bus.base_z <= '0;
    item_bus.world_x <= '0;
    item_bus.world_y <= '0;
    item_bus.world_z <= '0;
    item_bus.tool_x <= '0;
    item_bus.tool_y <= '0;
    item_bus.tool_z <= '0;
    item_bus.tool_ground_z <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CFG_X_LIMIT;
    cfg_bus.data <= '0;

    // Directed table, run on the reset limits with an empty store.
    // Empty store: the tool height alone picks the command.
    add_row(scan_item(0, 0, 0, 600), 1'b1, word(0, 0, ARM_SLOW_DOWN, 0));
    add_row(scan_item(-131072, -131072, -131072, 299), 1'b1,
            word(0, 0, ARM_SLOW_UP, 0));
    add_row(scan_item(131071, 131071, 131071, 300), 1'b1, word(0, 0, ARM_NONE, 0));
    add_row(scan_item(0, 0, 0, 500), 1'b1, word(0, 0, ARM_NONE, 0));
    add_row(scan_item(0, 0, 0, -131072), 1'b1, word(0, 0, ARM_SLOW_UP, 0));
    add_row(scan_item(0, 0, 0, 131071), 1'b1, word(0, 0, ARM_SLOW_DOWN, 0));
    // Points just outside each filter bound are rejected.
    add_row(point_item(5000, 0, 1000, 0, 0, 0), 1'b1, word(0, 0, ARM_NONE, 0));
    add_row(point_item(0, 5000, 1000, 0, 0, 0), 1'b1, word(0, 0, ARM_NONE, 0));
    add_row(point_item(0, -131072, 1000, 0, 0, 0), 1'b1, word(0, 0, ARM_NONE, 0));
    add_row(point_item(0, 0, 2000, 0, 0, 0), 1'b1, word(0, 0, ARM_NONE, 0));
    add_row(point_item(0, 0, 200, 0, 0, 0), 1'b1, word(0, 0, ARM_NONE, 0));
    add_row(point_item(131071, 131071, 131071, 0, 0, 0), 1'b1,
            word(0, 0, ARM_NONE, 0));
    // First obstacle at the world-coordinate corner.
    add_row(point_item(4999, -4999, 1999, -131072, 131071, -131072), 1'b1,
            word(1, 0, ARM_NONE, 1));
    // A near repeat of it, then two z steps away, the far corner, and truncation near zero.
    add_row(point_item(-131072, 4999, 201, -131001, 131000, -131049), 1'b0, '0);
    add_row(point_item(0, 0, 1000, -131072, 131071, -130950), 1'b0, '0);
    add_row(point_item(0, 0, 1000, 131071, -131072, 131071), 1'b0, '0);
    add_row(point_item(0, 0, 1000, -99, 99, -49), 1'b0, '0);
    add_row(point_item(0, 0, 1000, 199, 0, 0), 1'b0, '0);
    add_row(point_item(0, 0, 1000, 300, 0, 0), 1'b0, '0);
    // Clearance window edges around the obstacles near the origin.
    add_row(scan_item(1200, -1200, 300, 0), 1'b0, '0);
    add_row(scan_item(1501, 0, 0, 0), 1'b0, '0);
    add_row(scan_item(0, 0, 301, 400), 1'b0, '0);
    add_row(scan_item(0, 0, -131072, 400), 1'b0, '0);
    add_row(point_item(-131072, 0, 1000, int'(rnd_coord()), int'(rnd_coord()),
                       int'(rnd_coord())), 1'b0, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[r])
      offer_item(script[r].word, script[r].typed, script[r].want);

    // Random phases, each with its own limits and idle pattern.
    for (int p = 0; p < 5; p++) begin
      drain();
      write_regs(fwd_tab[p], side_tab[p], floor_tab[p]);
      send_idle_pct = idle_tab[p];
      stall_pct     = stall_tab[p];
      // in the phase with a busy sender, hold off the result side for a while
      if (p == 0)
        hold_off_req = 1'b1;
      repeat (ITEMS_PER_PHASE)
        offer_item(random_item(), 1'b0, '0);
    end

    drain();
    // let any stray word show up before the verdict
    repeat (STORE_DEPTH + 16) @(posedge clk_i);

    if (n_bad == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
